FILE: sv/sxb_pkg.sv
`default_nettype none
package sxb_pkg;

  // Display geometry
  localparam int DISP_WIDTH  = 64;
  localparam int DISP_HEIGHT = 32;

  localparam int PAT_BITS = 8;
  localparam int ROW_BITS = 64;
  localparam int XW       = $clog2(DISP_WIDTH);
  localparam int YW       = $clog2(DISP_HEIGHT);
  localparam int COL_W    = $clog2(PAT_BITS);

  typedef enum logic [1:0] {
    CMD_DRAW  = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  // What one lane hands to the merge stage
  typedef struct packed {
    logic [ROW_BITS-1:0] mask;
    logic                hit;
  } lane_res_t;

  typedef logic [XW-1:0] xtab_t [256];
  typedef logic [YW-1:0] ytab_t [256];
  typedef logic [YW-1:0] rtab_t [16];

  // Build the wrap tables at elaboration
  function automatic xtab_t build_xtab();
    xtab_t t;
    for (int i = 0; i < 256; i++) t[i] = XW'(i % DISP_WIDTH);
    return t;
  endfunction

  function automatic ytab_t build_ytab();
    ytab_t t;
    for (int i = 0; i < 256; i++) t[i] = YW'(i % DISP_HEIGHT);
    return t;
  endfunction

  function automatic rtab_t build_rtab();
    rtab_t t;
    for (int i = 0; i < 16; i++) t[i] = YW'(i % DISP_HEIGHT);
    return t;
  endfunction

  localparam xtab_t XMOD_TAB = build_xtab();
  localparam ytab_t YMOD_TAB = build_ytab();
  localparam rtab_t RMOD_TAB = build_rtab();

endpackage
`default_nettype wire

FILE: sv/sxb_lane.sv
`default_nettype none
module sxb_lane
  import sxb_pkg::*;
(
  input  wire logic [XW-1:0]       sx_mod,
  input  wire logic [COL_W-1:0]    lane_col,
  input  wire logic                pat_bit,
  input  wire logic [ROW_BITS-1:0] line,
  output lane_res_t                res
);

  logic [XW:0]   pos_sum;
  logic [XW:0]   pos_wrap;
  logic [XW-1:0] pos;

  // Wrap the column: both terms are below the width, so one subtract
  assign pos_sum  = {1'b0, sx_mod} + (XW+1)'(lane_col);
  assign pos_wrap = (pos_sum >= (XW+1)'(DISP_WIDTH)) ?
                    pos_sum - (XW+1)'(DISP_WIDTH) : pos_sum;
  assign pos      = pos_wrap[XW-1:0];

  // Flip mask and hit test for this pixel
  assign res.mask = pat_bit ? (ROW_BITS'(1) << pos) : '0;
  assign res.hit  = |(line & res.mask);

endmodule
`default_nettype wire

FILE: sv/sxb_merge.sv
`default_nettype none
module sxb_merge
  import sxb_pkg::*;
(
  input  wire lane_res_t            lane_res [PAT_BITS],
  input  wire logic [ROW_BITS-1:0]  line,
  output logic      [ROW_BITS-1:0]  new_line,
  output logic                      hit_any
);

  logic [ROW_BITS-1:0] flip;

  // Combine the lanes: masks touch distinct pixels
  always_comb begin
    flip    = '0;
    hit_any = 1'b0;
    for (int i = 0; i < PAT_BITS; i++) begin
      flip    = flip ^ lane_res[i].mask;
      hit_any = hit_any | lane_res[i].hit;
    end
    new_line = line ^ flip;
  end

endmodule
`default_nettype wire

FILE: sv/sprite_xor_blit_collision.sv
// Monochrome XOR framebuffer with sprite collision detection.
// Input channel (in_*): one item per command. Draw XORs an 8-pixel sprite
// row into the store, wrapping on both axes; clear blanks the store; read
// returns one 64-bit row (bit 0 is column 0). Code 3 is ignored.
// Output channel (out_*): exactly one item per input item, in order.
// Draw gives the collision flag accumulated since row index 0 and a copy of
// last_row in sprite_done; read gives row_pixels; all else is zero.
// The result is registered at the accepting edge. Throughput: one item per
// cycle while the receiver does not stall, set by the single read-modify-write
// of one store row done in the accepting cycle.
// Eight pixel lanes test and flip their bits in parallel; a merge stage
// ORs the hits and XORs the masks back into the row.
// When the receiver stalls, the result holds and in_stall rises until it
// is taken. Reset (synchronous, rst_n low) blanks the display at once
// through per-row valid bits, clears the collision flag and empties the
// output register; no clearing pass is needed.
`default_nettype none
module sprite_xor_blit_collision
  import sxb_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [1:0]          in_cmd,
  input  wire logic [7:0]          in_sprite_x,
  input  wire logic [7:0]          in_sprite_y,
  input  wire logic [3:0]          in_row_index,
  input  wire logic [7:0]          in_row_bits,
  input  wire logic                in_last_row,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic                     out_collision,
  output logic                     out_sprite_done,
  output logic [ROW_BITS-1:0]      out_row_pixels
);

  logic [ROW_BITS-1:0] frame_r [DISP_HEIGHT];
  logic [DISP_HEIGHT-1:0] row_vld_r;
  logic                coll_acc_r;
  logic                out_vld_r;
  logic                out_coll_r;
  logic                out_done_r;
  logic [ROW_BITS-1:0] out_pix_r;

  cmd_t                cmd;
  logic                in_acc;
  logic [XW-1:0]       sx_mod;
  logic [YW-1:0]       sy_mod;
  logic [YW:0]         ysum;
  logic [YW-1:0]       ydraw;
  logic [YW-1:0]       raddr;
  logic [ROW_BITS-1:0] line;
  logic [ROW_BITS-1:0] new_line;
  logic                hit_any;
  logic                coll_nxt;
  lane_res_t           lane_res [PAT_BITS];

  assign cmd      = cmd_t'(in_cmd);
  assign in_stall = out_vld_r && out_stall;
  assign in_acc   = in_valid && !in_stall;

  // Wrap origin and target row
  assign sx_mod = XMOD_TAB[in_sprite_x];
  assign sy_mod = YMOD_TAB[in_sprite_y];
  assign ysum   = {1'b0, sy_mod} + {1'b0, RMOD_TAB[in_row_index]};
  assign ydraw  = (ysum >= (YW+1)'(DISP_HEIGHT)) ?
                  YW'(ysum - (YW+1)'(DISP_HEIGHT)) : ysum[YW-1:0];
  assign raddr  = (cmd == CMD_READ) ? sy_mod : ydraw;

  // Single row read; an invalid row reads as blank
  assign line = row_vld_r[raddr] ? frame_r[raddr] : '0;

  // Pixel lanes
  for (genvar g = 0; g < PAT_BITS; g++) begin : g_lane
    sxb_lane u_lane (
      .sx_mod   (sx_mod),
      .lane_col (COL_W'(g)),
      .pat_bit  (in_row_bits[PAT_BITS-1-g]),
      .line     (line),
      .res      (lane_res[g])
    );
  end

  sxb_merge u_merge (
    .lane_res (lane_res),
    .line     (line),
    .new_line (new_line),
    .hit_any  (hit_any)
  );

  // Row 0 restarts the accumulation
  assign coll_nxt = ((in_row_index == 4'd0) ? 1'b0 : coll_acc_r) | hit_any;

  // Store write-back
  always_ff @(posedge clk) begin
    if (in_acc && cmd == CMD_DRAW) begin
      frame_r[ydraw] <= new_line;
    end
  end

  // Control state: row valid bits, collision flag, output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r  <= '0;
      coll_acc_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      if (in_acc) begin
        out_vld_r <= 1'b1;
      end else if (!out_stall) begin
        out_vld_r <= 1'b0;
      end
      if (in_acc) begin
        unique case (cmd)
          CMD_DRAW: begin
            row_vld_r[ydraw] <= 1'b1;
            coll_acc_r       <= coll_nxt;
          end
          CMD_CLEAR: row_vld_r <= '0;
          CMD_READ:  ;
          CMD_NONE:  ;
          default:   ;
        endcase
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_coll_r <= (cmd == CMD_DRAW) ? coll_nxt : 1'b0;
      out_done_r <= (cmd == CMD_DRAW) ? in_last_row : 1'b0;
      out_pix_r  <= (cmd == CMD_READ) ? line : '0;
    end
  end

  assign out_valid       = out_vld_r;
  assign out_collision   = out_coll_r;
  assign out_sprite_done = out_done_r;
  assign out_row_pixels  = out_pix_r;

  // Checks
  a_read_no_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && (out_pix_r != '0) |-> !out_coll_r && !out_done_r)
    else $error("read result carries draw flags");

  a_clear_blanks: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && cmd == CMD_CLEAR |=> row_vld_r == '0)
    else $error("clear left a row valid");

  a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_vld_r |-> !in_stall)
    else $error("input stalled with empty output register");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> out_vld_r)
    else $error("accepted item produced no result");

endmodule
`default_nettype wire

FILE: tb/sprite_xor_blit_collision_tb.sv
`timescale 1ns / 1ps

module sprite_xor_blit_collision_tb;
  import sxb_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_ITEMS = 800;
  localparam int MAX_REPORTS  = 10;

  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] sx;
    logic [7:0] sy;
    logic [3:0] ridx;
    logic [7:0] bits;
    logic       last;
    logic       settle;  // hold this item back until every result is in
  } blit_item_t;

  typedef struct packed {
    logic                collision;
    logic                done;
    logic [ROW_BITS-1:0] pixels;
  } blit_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [1:0]          in_cmd = CMD_NONE;
  logic [7:0]          in_sprite_x = 8'd0;
  logic [7:0]          in_sprite_y = 8'd0;
  logic [3:0]          in_row_index = 4'd0;
  logic [7:0]          in_row_bits = 8'd0;
  logic                in_last_row = 1'b0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic                out_collision;
  logic                out_sprite_done;
  logic [ROW_BITS-1:0] out_row_pixels;

  // Shadow copy of the display and the collision flag
  logic [ROW_BITS-1:0] shadow_frame [DISP_HEIGHT];
  logic                shadow_hit;

  blit_item_t   pending_items [$];
  blit_result_t awaited_results [$];

  blit_item_t cur_item;
  logic       send_next;
  int         send_wait = 0;
  logic       send_calm = 1'b0;
  int         stall_left = 0;
  logic       recv_calm = 1'b0;
  logic       drain_next = 1'b0;

  int errors = 0;
  int cycle_count = 0;
  int queued_items = 0;
  int n_draw = 0, n_read = 0, n_clear = 0, n_idle = 0;
  int results_checked = 0;
  int hits_seen = 0;
  int drain_points = 0;

  sprite_xor_blit_collision dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_cmd          (in_cmd),
    .in_sprite_x     (in_sprite_x),
    .in_sprite_y     (in_sprite_y),
    .in_row_index    (in_row_index),
    .in_row_bits     (in_row_bits),
    .in_last_row     (in_last_row),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_collision   (out_collision),
    .out_sprite_done (out_sprite_done),
    .out_row_pixels  (out_row_pixels)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Apply one accepted item to the shadow display and return its result
  function automatic blit_result_t predict_blit(input blit_item_t it);
    blit_result_t        r;
    logic [ROW_BITS-1:0] line;
    int                  yrow;
    int                  xpos;
    r = '0;
    case (it.cmd)
      CMD_DRAW: begin
        yrow = (int'(it.sy) + int'(it.ridx)) % DISP_HEIGHT;
        line = shadow_frame[yrow];
        if (it.ridx == 4'd0) shadow_hit = 1'b0;
        for (int c = 0; c < PAT_BITS; c++) begin
          if (it.bits[PAT_BITS-1-c]) begin
            xpos = (int'(it.sx) + c) % DISP_WIDTH;
            if (line[xpos]) shadow_hit = 1'b1;
            line[xpos] = ~line[xpos];
          end
        end
        shadow_frame[yrow] = line;
        r.collision = shadow_hit;
        r.done      = it.last;
      end
      CMD_CLEAR: begin
        for (int y = 0; y < DISP_HEIGHT; y++) shadow_frame[y] = '0;
      end
      CMD_READ: begin
        r.pixels = shadow_frame[int'(it.sy) % DISP_HEIGHT];
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic void flag_error(input string msg);
    errors++;
    if (errors <= MAX_REPORTS) $display("ERROR @%0d: %s", cycle_count, msg);
  endfunction

  // Build one item and append it to the send queue
  task automatic queue_item(input cmd_t cmd, input int x, input int y, input int r,
                            input int bits, input logic last);
    blit_item_t it;
    it.cmd    = cmd;
    it.sx     = 8'(x);
    it.sy     = 8'(y);
    it.ridx   = 4'(r);
    it.bits   = 8'(bits);
    it.last   = last;
    it.settle = drain_next;
    drain_next = 1'b0;
    pending_items.push_back(it);
    if (cmd != CMD_NONE) queued_items++;
  endtask

  // Cycle counter and watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Regression FAIL");
      $finish;
    end
  end

  // Driver: predict on acceptance, then present the next item after its gap
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_wait = 0;
    end else begin
      send_next = in_valid;
      if (in_valid && !in_stall) begin
        awaited_results.push_back(predict_blit(cur_item));
        case (cur_item.cmd)
          CMD_DRAW:  n_draw++;
          CMD_READ:  n_read++;
          CMD_CLEAR: n_clear++;
          default:   n_idle++;
        endcase
        send_wait = send_calm ? 0 : $urandom_range(0, 3);
        if ($urandom_range(0, 47) == 0) send_calm = !send_calm;
        send_next = 1'b0;
      end
      if (!send_next) begin
        if (send_wait > 0) begin
          send_wait--;
        end else if (pending_items.size() > 0 &&
                     (!pending_items[0].settle || awaited_results.size() == 0)) begin
          cur_item = pending_items.pop_front();
          if (cur_item.settle) drain_points++;
          in_cmd       <= cur_item.cmd;
          in_sprite_x  <= cur_item.sx;
          in_sprite_y  <= cur_item.sy;
          in_row_index <= cur_item.ridx;
          in_row_bits  <= cur_item.bits;
          in_last_row  <= cur_item.last;
          send_next = 1'b1;
        end
      end
      in_valid <= send_next;
    end
  end

  // Monitor: check each taken result against the oldest prediction
  always @(posedge clk) begin
    blit_result_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (awaited_results.size() == 0) begin
          flag_error("result arrived with nothing outstanding");
        end else begin
          want = awaited_results.pop_front();
          results_checked++;
          if (out_collision === 1'b1) hits_seen++;
          if (out_collision !== want.collision)
            flag_error($sformatf("collision exp %0b got %0b", want.collision, out_collision));
          if (out_sprite_done !== want.done)
            flag_error($sformatf("sprite_done exp %0b got %0b", want.done, out_sprite_done));
          if (out_row_pixels !== want.pixels)
            flag_error($sformatf("row_pixels exp %016h got %016h",
                                 want.pixels, out_row_pixels));
        end
        stall_left = recv_calm ? 0 : $urandom_range(0, 3);
        if ($urandom_range(0, 47) == 0) recv_calm = !recv_calm;
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    int         pick;
    int         x, y, h;
    logic [7:0] pat [16];

    for (int i = 0; i < DISP_HEIGHT; i++) shadow_frame[i] = '0;
    shadow_hit = 1'b0;

    // Directed: empty read, erase by redraw, wrap on both axes
    queue_item(CMD_READ,  0,   0,   0,  8'h00, 1'b0);
    queue_item(CMD_DRAW,  0,   0,   0,  8'hFF, 1'b1);
    queue_item(CMD_DRAW,  0,   0,   0,  8'hFF, 1'b1);
    queue_item(CMD_READ,  0,   0,   0,  8'h00, 1'b0);
    queue_item(CMD_DRAW,  60,  31,  0,  8'hFF, 1'b0);
    queue_item(CMD_DRAW,  60,  31,  1,  8'h81, 1'b1);
    queue_item(CMD_READ,  0,   255, 0,  8'h00, 1'b0);
    queue_item(CMD_READ,  0,   32,  0,  8'h00, 1'b0);
    // Origins at the top of their range, row index past any sprite height
    queue_item(CMD_DRAW,  255, 255, 15, 8'hAA, 1'b1);
    queue_item(CMD_READ,  255, 14,  15, 8'hFF, 1'b1);
    // Collision raised in a later row and held to the end of the sprite
    queue_item(CMD_DRAW,  0,   5,   0,  8'h00, 1'b0);
    queue_item(CMD_DRAW,  0,   5,   1,  8'h01, 1'b0);
    queue_item(CMD_DRAW,  7,   5,   1,  8'h80, 1'b0);
    queue_item(CMD_DRAW,  40,  5,   2,  8'h3C, 1'b1);
    // Clear keeps the collision flag
    queue_item(CMD_CLEAR, 255, 255, 15, 8'hFF, 1'b1);
    queue_item(CMD_DRAW,  0,   5,   3,  8'h01, 1'b0);
    queue_item(CMD_READ,  0,   8,   0,  8'h00, 1'b0);
    // Unused command is ignored
    queue_item(CMD_NONE,  255, 255, 15, 8'hFF, 1'b1);
    // New sprite starts on row 0 without a last row before it
    queue_item(CMD_DRAW,  10,  10,  0,  8'hFF, 1'b0);
    queue_item(CMD_DRAW,  10,  10,  0,  8'h0F, 1'b1);
    queue_item(CMD_READ,  0,   10,  0,  8'h00, 1'b0);
    queue_item(CMD_CLEAR, 0,   0,   0,  8'h00, 1'b0);
    queue_item(CMD_READ,  0,   31,  0,  8'h00, 1'b0);

    // Random: mostly whole sprites, some reads and clears, some noise
    drain_next = 1'b1;
    while (queued_items < 23 + RANDOM_ITEMS) begin
      if ($urandom_range(0, 59) == 0) drain_next = 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        x = $urandom_range(0, 255);
        y = $urandom_range(0, 255);
        h = $urandom_range(0, 15);
        for (int r = 0; r < h; r++) begin
          pat[r] = 8'($urandom);
          queue_item(CMD_DRAW, x, y, r, pat[r], r == h - 1);
        end
        // Redraw the same sprite now and then to erase it
        if ($urandom_range(0, 3) == 0) begin
          for (int r = 0; r < h; r++) queue_item(CMD_DRAW, x, y, r, pat[r], r == h - 1);
        end
      end else if (pick < 78) begin
        queue_item(CMD_READ, $urandom, $urandom_range(0, 255), $urandom, $urandom, $urandom);
      end else if (pick < 81) begin
        queue_item(CMD_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom);
      end else if (pick < 86) begin
        queue_item(CMD_NONE, $urandom, $urandom, $urandom, $urandom, $urandom);
      end else begin
        queue_item(CMD_DRAW, $urandom_range(0, 255), $urandom_range(0, 255),
                   $urandom_range(0, 15), $urandom_range(0, 255), $urandom);
      end
    end

    // Hold reset, then release on a clock edge
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for the queue to empty and every result to be taken
    while (pending_items.size() > 0 || in_valid || awaited_results.size() > 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
    if (awaited_results.size() != 0)
      flag_error($sformatf("%0d results never arrived", awaited_results.size()));

    $display("Sent %0d draws, %0d reads, %0d clears, %0d unused codes; %0d drain points.",
             n_draw, n_read, n_clear, n_idle, drain_points);
    $display("Checked %0d results, %0d with collision set; %0d mismatches.",
             results_checked, hits_seen, errors);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
